FILE: rtl/lrd_pkg.sv
// Shared types, codes and the CRC-32 byte step for the log record deframer.
package lrd_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Result kinds
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_VAL  = 2'd1;
  localparam logic [1:0] KIND_REC  = 2'd2;
  localparam logic [1:0] KIND_EOL  = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_TRUNC    = 2'd2;

  // Register addresses
  localparam logic [0:0] ADDR_MIN_SEQUENCE = 1'b0;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  data_byte;
    logic [7:0]  rec_kind;
    logic [63:0] txn_ident;
    logic [63:0] seq_number;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [1:0]  status;
    logic        selected;
    logic [63:0] highest_seq;
    logic        last_of_run;
  } res_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/lrd_if.sv
// Handshake channels of the log record deframer: byte input and result output.
interface lrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface lrd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  data_byte;
  logic [7:0]  rec_kind;
  logic [63:0] txn_ident;
  logic [63:0] seq_number;
  logic [31:0] key_length;
  logic [31:0] value_length;
  logic [1:0]  status;
  logic        selected;
  logic [63:0] highest_seq;
  logic        last_of_run;

  modport source (output valid, output out_kind, output data_byte, output rec_kind,
                  output txn_ident, output seq_number, output key_length,
                  output value_length, output status, output selected,
                  output highest_seq, output last_of_run, input ready);
  modport sink (input valid, input out_kind, input data_byte, input rec_kind,
                input txn_ident, input seq_number, input key_length,
                input value_length, input status, input selected,
                input highest_seq, input last_of_run, output ready);
endinterface

FILE: rtl/log_record_deframer_crc32.sv
// Log record deframer: parses a byte stream of records and checks each CRC-32.
// Results of a byte enter the output queue in the cycle after it is taken.
// Throughput: one byte per cycle; a byte may give two results (data byte or record
//   end, plus end of log), while the queue drains one result per cycle when results.ready
//   is high, so ready drops when fewer than two slots are free.
// Reset (rst, synchronous): parser back to the kind field, CRC all ones, queue empty,
//   min_sequence zero.
module log_record_deframer_crc32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  lrd_byte_if.sink    bytes,
  lrd_res_if.source   results
);

  // Parser phases, in record order
  localparam logic [2:0] PH_KIND = 3'd0;
  localparam logic [2:0] PH_TXN  = 3'd1;
  localparam logic [2:0] PH_SEQ  = 3'd2;
  localparam logic [2:0] PH_KLEN = 3'd3;
  localparam logic [2:0] PH_KEY  = 3'd4;
  localparam logic [2:0] PH_VLEN = 3'd5;
  localparam logic [2:0] PH_VAL  = 3'd6;
  localparam logic [2:0] PH_CRC  = 3'd7;

  // Configuration register
  logic [63:0] min_sequence;

  // Parser state
  logic [2:0]  parse_phase, parse_phase_next;
  logic [31:0] field_count, field_count_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [7:0]  hdr_kind, hdr_kind_next;
  logic [63:0] hdr_txn, hdr_txn_next;
  logic [63:0] hdr_seq, hdr_seq_next;
  logic [31:0] hdr_key_len, hdr_key_len_next;
  logic [31:0] hdr_value_len, hdr_value_len_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic        halted, halted_next;
  logic [63:0] max_seen_seq, max_seen_seq_next;

  // Result queue: four slots, up to two written and one read per cycle
  lrd_pkg::res_t queue [4];
  logic [1:0]    wr_ptr, rd_ptr;
  logic [2:0]    count, count_next;

  logic          take, pop;
  logic          have_a;
  lrd_pkg::res_t res_a, res_b, res_first;
  logic [1:0]    n_push;

  logic [31:0]   count_inc;
  logic [31:0]   len_full;
  logic [31:0]   crc_full;
  logic [7:0]    b;
  logic [31:0]   crc_stepped;
  logic          crc_ok;

  assign b           = bytes.in_byte;
  assign take        = bytes.valid && bytes.ready;
  assign pop         = results.valid && results.ready;
  assign count_inc   = field_count + 32'd1;
  assign crc_stepped = lrd_pkg::crc_byte(crc_reg, b);

  // Configuration port: one 64-bit register, always ready
  assign pready = 1'b1;
  assign prdata = min_sequence;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sequence <= '0;
    end else if (psel && penable && pwrite && paddr == lrd_pkg::ADDR_MIN_SEQUENCE) begin
      min_sequence <= pwdata;
    end
  end

  // Per-byte step: field assembly, CRC update and result building
  always_comb begin
    parse_phase_next   = parse_phase;
    field_count_next   = field_count;
    crc_reg_next       = crc_reg;
    hdr_kind_next      = hdr_kind;
    hdr_txn_next       = hdr_txn;
    hdr_seq_next       = hdr_seq;
    hdr_key_len_next   = hdr_key_len;
    hdr_value_len_next = hdr_value_len;
    stored_crc_next    = stored_crc;
    halted_next        = halted;
    max_seen_seq_next  = max_seen_seq;
    have_a             = 1'b0;
    res_a              = '0;
    res_b              = '0;
    len_full           = '0;
    crc_full           = '0;
    crc_ok             = 1'b0;

    if (take && !halted) begin
      case (parse_phase)
        PH_KIND: begin
          // State is already clear here; latch the kind and fold it into the CRC
          hdr_kind_next    = b;
          crc_reg_next     = crc_stepped;
          field_count_next = '0;
          parse_phase_next = PH_TXN;
        end
        PH_TXN, PH_SEQ: begin
          if (parse_phase == PH_TXN) begin
            hdr_txn_next[{field_count[2:0], 3'b000} +: 8] = b;
          end else begin
            hdr_seq_next[{field_count[2:0], 3'b000} +: 8] = b;
          end
          crc_reg_next = crc_stepped;
          if (field_count[2:0] == 3'd7) begin
            field_count_next = '0;
            parse_phase_next = parse_phase + 3'd1;
          end else begin
            field_count_next = count_inc;
          end
        end
        PH_KLEN, PH_VLEN: begin
          // Length bytes stay out of the CRC; a zero length skips its data phase
          if (parse_phase == PH_KLEN) begin
            hdr_key_len_next[{field_count[1:0], 3'b000} +: 8] = b;
            len_full = {b, hdr_key_len[23:0]};
          end else begin
            hdr_value_len_next[{field_count[1:0], 3'b000} +: 8] = b;
            len_full = {b, hdr_value_len[23:0]};
          end
          if (field_count[1:0] == 2'd3) begin
            field_count_next = '0;
            parse_phase_next = (len_full == 32'd0) ? parse_phase + 3'd2
                                                   : parse_phase + 3'd1;
          end else begin
            field_count_next = count_inc;
          end
        end
        PH_KEY, PH_VAL: begin
          have_a             = 1'b1;
          res_a.out_kind     = (parse_phase == PH_KEY) ? lrd_pkg::KIND_KEY
                                                       : lrd_pkg::KIND_VAL;
          res_a.data_byte    = b;
          crc_reg_next       = crc_stepped;
          if (count_inc >= ((parse_phase == PH_KEY) ? hdr_key_len : hdr_value_len)) begin
            field_count_next = '0;
            parse_phase_next = parse_phase + 3'd1;
          end else begin
            field_count_next = count_inc;
          end
        end
        default: begin
          // Checksum bytes: compare on the last one and close the record
          stored_crc_next[{field_count[1:0], 3'b000} +: 8] = b;
          crc_full = {b, stored_crc[23:0]};
          crc_ok   = (crc_reg ^ lrd_pkg::CRC_INIT) == crc_full;
          if (field_count[1:0] == 2'd3) begin
            have_a             = 1'b1;
            res_a.out_kind     = lrd_pkg::KIND_REC;
            res_a.rec_kind     = hdr_kind;
            res_a.txn_ident    = hdr_txn;
            res_a.seq_number   = hdr_seq;
            res_a.key_length   = hdr_key_len;
            res_a.value_length = hdr_value_len;
            res_a.status       = crc_ok ? lrd_pkg::STAT_OK : lrd_pkg::STAT_MISMATCH;
            res_a.selected     = crc_ok && (hdr_seq >= min_sequence);
            if (crc_ok) begin
              if (hdr_seq > max_seen_seq) begin
                max_seen_seq_next = hdr_seq;
              end
            end else begin
              halted_next = 1'b1;
            end
            parse_phase_next   = PH_KIND;
            field_count_next   = '0;
            crc_reg_next       = lrd_pkg::CRC_INIT;
            hdr_kind_next      = '0;
            hdr_txn_next       = '0;
            hdr_seq_next       = '0;
            hdr_key_len_next   = '0;
            hdr_value_len_next = '0;
            stored_crc_next    = '0;
          end else begin
            field_count_next = count_inc;
          end
        end
      endcase
    end

    // End of log: report, then restart the parser from clean state
    if (take && bytes.final_byte) begin
      res_b.out_kind     = lrd_pkg::KIND_EOL;
      res_b.status       = (!halted_next && parse_phase_next != PH_KIND)
                           ? lrd_pkg::STAT_TRUNC : lrd_pkg::STAT_OK;
      res_b.highest_seq  = max_seen_seq_next;
      res_b.last_of_run  = 1'b1;
      parse_phase_next   = PH_KIND;
      field_count_next   = '0;
      crc_reg_next       = lrd_pkg::CRC_INIT;
      hdr_kind_next      = '0;
      hdr_txn_next       = '0;
      hdr_seq_next       = '0;
      hdr_key_len_next   = '0;
      hdr_value_len_next = '0;
      stored_crc_next    = '0;
      halted_next        = 1'b0;
      max_seen_seq_next  = '0;
    end

    res_a.last_of_run = !(take && bytes.final_byte);
  end

  // Order the results of this byte: data or record end first, end of log last
  assign res_first = have_a ? res_a : res_b;
  assign n_push    = {1'b0, have_a} + {1'b0, take && bytes.final_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_KIND;
      field_count   <= '0;
      crc_reg       <= lrd_pkg::CRC_INIT;
      hdr_kind      <= '0;
      hdr_txn       <= '0;
      hdr_seq       <= '0;
      hdr_key_len   <= '0;
      hdr_value_len <= '0;
      stored_crc    <= '0;
      halted        <= 1'b0;
      max_seen_seq  <= '0;
    end else begin
      parse_phase   <= parse_phase_next;
      field_count   <= field_count_next;
      crc_reg       <= crc_reg_next;
      hdr_kind      <= hdr_kind_next;
      hdr_txn       <= hdr_txn_next;
      hdr_seq       <= hdr_seq_next;
      hdr_key_len   <= hdr_key_len_next;
      hdr_value_len <= hdr_value_len_next;
      stored_crc    <= stored_crc_next;
      halted        <= halted_next;
      max_seen_seq  <= max_seen_seq_next;
    end
  end

  // Queue storage: no reset needed on the slots
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue[wr_ptr] <= res_first;
    end
    if (n_push == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res_b;
    end
  end

  assign count_next = count + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  // Take a byte only while at least two slots are free
  assign bytes.ready = (count <= 3'd2);

  assign results.valid        = (count != 3'd0);
  assign results.out_kind     = queue[rd_ptr].out_kind;
  assign results.data_byte    = queue[rd_ptr].data_byte;
  assign results.rec_kind     = queue[rd_ptr].rec_kind;
  assign results.txn_ident    = queue[rd_ptr].txn_ident;
  assign results.seq_number   = queue[rd_ptr].seq_number;
  assign results.key_length   = queue[rd_ptr].key_length;
  assign results.value_length = queue[rd_ptr].value_length;
  assign results.status       = queue[rd_ptr].status;
  assign results.selected     = queue[rd_ptr].selected;
  assign results.highest_seq  = queue[rd_ptr].highest_seq;
  assign results.last_of_run  = queue[rd_ptr].last_of_run;

  // Checks
  a_count_bound: assert property (@(posedge clk) count <= 3'd4)
    else $error("result queue overfilled");

  a_reset_empty: assert property (@(posedge clk) rst |=> count == 3'd0)
    else $error("queue not empty after reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (take && halted && !bytes.final_byte && !pop) |=> count == $past(count))
    else $error("halted parser produced a result");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (take && bytes.final_byte) |=> (!halted && parse_phase == PH_KIND
                                     && max_seen_seq == 64'd0))
    else $error("parser not restarted after final byte");

endmodule

FILE: test/lrd_frame_checker.sv
// Follows both channels and the register port, predicts every result and compares it.
module lrd_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  lrd_byte_if         bytes,
  lrd_res_if          results,
  output int          fails,
  output int          pending
);

  typedef enum logic [2:0] {
    FLD_KIND, FLD_TXN, FLD_SEQ, FLD_KLEN, FLD_KEY, FLD_VLEN, FLD_VAL, FLD_SUM
  } field_e;

  logic [63:0]   min_seq;
  field_e        fld;
  logic [31:0]   cnt;
  logic [31:0]   crc;
  logic [31:0]   sum;
  logic [7:0]    kind;
  logic [63:0]   txn;
  logic [63:0]   seq;
  logic [31:0]   klen;
  logic [31:0]   vlen;
  logic          hold;
  logic [63:0]   top_seq;
  lrd_pkg::res_t due_results[$];
  lrd_pkg::res_t want;
  int            mismatch_count = 0;

  // Serial form of the reflected CRC-32: one message bit per shift.
  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    logic        fb;
    v = c;
    for (int i = 0; i < 8; i++) begin
      fb = v[0] ^ b[i];
      v  = {1'b0, v[31:1]} ^ (fb ? lrd_pkg::CRC_POLY : 32'h0);
    end
    return v;
  endfunction

  task automatic clear_frame();
    fld  = FLD_KIND;
    cnt  = '0;
    crc  = lrd_pkg::CRC_INIT;
    sum  = '0;
    kind = '0;
    txn  = '0;
    seq  = '0;
    klen = '0;
    vlen = '0;
  endtask

  // Advance the parser by one byte and queue the results it causes.
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    lrd_pkg::res_t r[2];
    int            n;
    logic          ok;
    n    = 0;
    r[0] = '0;
    r[1] = '0;
    if (!hold) begin
      case (fld)
        FLD_KIND: begin
          clear_frame();
          kind = b;
          crc  = crc_next(crc, b);
          fld  = FLD_TXN;
        end
        FLD_TXN, FLD_SEQ: begin
          if (fld == FLD_TXN) txn[{cnt[2:0], 3'b000} +: 8] = b;
          else seq[{cnt[2:0], 3'b000} +: 8] = b;
          crc = crc_next(crc, b);
          cnt = cnt + 1;
          if (cnt == 32'd8) begin
            cnt = '0;
            fld = (fld == FLD_TXN) ? FLD_SEQ : FLD_KLEN;
          end
        end
        FLD_KLEN, FLD_VLEN: begin
          if (fld == FLD_KLEN) klen[{cnt[1:0], 3'b000} +: 8] = b;
          else vlen[{cnt[1:0], 3'b000} +: 8] = b;
          cnt = cnt + 1;
          if (cnt == 32'd4) begin
            cnt = '0;
            if (fld == FLD_KLEN) fld = (klen == '0) ? FLD_VLEN : FLD_KEY;
            else fld = (vlen == '0) ? FLD_SUM : FLD_VAL;
          end
        end
        FLD_KEY, FLD_VAL: begin
          r[n].out_kind  = (fld == FLD_KEY) ? lrd_pkg::KIND_KEY : lrd_pkg::KIND_VAL;
          r[n].data_byte = b;
          n++;
          crc = crc_next(crc, b);
          cnt = cnt + 1;
          if (cnt == ((fld == FLD_KEY) ? klen : vlen)) begin
            cnt = '0;
            fld = (fld == FLD_KEY) ? FLD_VLEN : FLD_SUM;
          end
        end
        default: begin
          sum[{cnt[1:0], 3'b000} +: 8] = b;
          cnt = cnt + 1;
          if (cnt == 32'd4) begin
            ok = ((crc ^ lrd_pkg::CRC_INIT) == sum);
            r[n].out_kind     = lrd_pkg::KIND_REC;
            r[n].rec_kind     = kind;
            r[n].txn_ident    = txn;
            r[n].seq_number   = seq;
            r[n].key_length   = klen;
            r[n].value_length = vlen;
            r[n].status       = ok ? lrd_pkg::STAT_OK : lrd_pkg::STAT_MISMATCH;
            r[n].selected     = ok && (seq >= min_seq);
            n++;
            if (ok) begin
              if (seq > top_seq) top_seq = seq;
            end else begin
              hold = 1'b1;
            end
            clear_frame();
          end
        end
      endcase
    end
    if (fin) begin
      r[n].out_kind    = lrd_pkg::KIND_EOL;
      r[n].status      = (!hold && fld != FLD_KIND) ? lrd_pkg::STAT_TRUNC
                                                    : lrd_pkg::STAT_OK;
      r[n].highest_seq = top_seq;
      n++;
      clear_frame();
      hold    = 1'b0;
      top_seq = '0;
    end
    if (n > 0) r[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) due_results = {due_results, r[i]};
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      min_seq = '0;
      clear_frame();
      hold    = 1'b0;
      top_seq = '0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == lrd_pkg::ADDR_MIN_SEQUENCE)
        min_seq = pwdata;
      // Take the new byte first so a result it causes at once still finds its entry.
      if (bytes.valid && bytes.ready) absorb_byte(bytes.in_byte, bytes.final_byte);
      if (results.valid && results.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                   $time, results.out_kind, results.data_byte);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("out_kind", 64'(want.out_kind), 64'(results.out_kind));
          check_field("data_byte", 64'(want.data_byte), 64'(results.data_byte));
          check_field("rec_kind", 64'(want.rec_kind), 64'(results.rec_kind));
          check_field("txn_ident", want.txn_ident, results.txn_ident);
          check_field("seq_number", want.seq_number, results.seq_number);
          check_field("key_length", 64'(want.key_length), 64'(results.key_length));
          check_field("value_length", 64'(want.value_length),
                      64'(results.value_length));
          check_field("status", 64'(want.status), 64'(results.status));
          check_field("selected", 64'(want.selected), 64'(results.selected));
          check_field("highest_seq", want.highest_seq, results.highest_seq);
          check_field("last_of_run", 64'(want.last_of_run), 64'(results.last_of_run));
        end
      end
    end
    fails   <= mismatch_count;
    pending <= due_results.size();
  end

endmodule

FILE: test/tb_log_record_deframer_crc32.sv
// Top of the deframer bench: builds log images, drives both channels and gives the verdict.
module tb_log_record_deframer_crc32;

  // Slowest correct run: about 2000 items, each up to two results behind a receiver that
  // idles 77 percent of the time, or a sender idling as often; the limit is set several times
  // over that worst case.
  localparam int RUN_LIMIT   = 500000;
  localparam int PHASE_ITEMS = 620;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  lrd_byte_if bytes_ch ();
  lrd_res_if  res_ch ();

  int          send_idle = 0;
  int          recv_idle = 0;
  int          cycles    = 0;
  int          sent      = 0;
  int          fails;
  int          pending;
  logic [63:0] cur_min   = '0;
  logic [7:0]  log_img[$];

  log_record_deframer_crc32 dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bytes   (bytes_ch),
    .results (res_ch)
  );

  lrd_frame_checker chk (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .bytes   (bytes_ch),
    .results (res_ch),
    .fails   (fails),
    .pending (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Receiver: drop ready at random, as often as the current phase asks.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog: give up if the run hangs.
  initial begin
    wait (cycles >= RUN_LIMIT);
    $display("log_record_deframer_crc32 verification failed");
    $finish;
  end

  // Reflected CRC-32 used to seal the generated records; mask form, xor first.
  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) v = (v >> 1) ^ (lrd_pkg::CRC_POLY & {32{v[0]}});
    return v;
  endfunction

  // Sequence numbers cluster round the current minimum so selected flips both ways;
  // the extremes and plain random values turn up too.
  function automatic logic [63:0] pick_seq();
    case ($urandom_range(0, 5))
      0:       return cur_min;
      1:       return cur_min - 64'd1;
      2:       return cur_min + 64'd1;
      3:       return {64{$urandom_range(0, 1) == 1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly short fields, a fair share empty, now and then a longer one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) return 0;
    if (r == 15) return $urandom_range(20, 40);
    return $urandom_range(1, 6);
  endfunction

  // Append one whole record to the image; spoil flips one checksum bit.
  task automatic add_record(input bit spoil);
    logic [31:0] c;
    logic [63:0] txn;
    logic [63:0] seq;
    logic [31:0] klen;
    logic [31:0] vlen;
    logic [7:0]  b;
    c   = lrd_pkg::CRC_INIT;
    txn = ($urandom_range(0, 7) == 0) ? {64{$urandom_range(0, 1) == 1}} : {$urandom, $urandom};
    seq = pick_seq();
    b   = 8'($urandom_range(0, 255));
    log_img = {log_img, b};
    c = crc_fold(c, b);
    for (int i = 0; i < 8; i++) begin
      log_img = {log_img, txn[8*i +: 8]};
      c = crc_fold(c, txn[8*i +: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      log_img = {log_img, seq[8*i +: 8]};
      c = crc_fold(c, seq[8*i +: 8]);
    end
    klen = pick_len();
    vlen = pick_len();
    // Lengths are framing only: they stay out of the checksum.
    for (int i = 0; i < 4; i++) log_img = {log_img, klen[8*i +: 8]};
    for (int i = 0; i < klen; i++) begin
      b = 8'($urandom_range(0, 255));
      log_img = {log_img, b};
      c = crc_fold(c, b);
    end
    for (int i = 0; i < 4; i++) log_img = {log_img, vlen[8*i +: 8]};
    for (int i = 0; i < vlen; i++) begin
      b = 8'($urandom_range(0, 255));
      log_img = {log_img, b};
      c = crc_fold(c, b);
    end
    c = c ^ lrd_pkg::CRC_INIT;
    if (spoil) c = c ^ (32'h1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) log_img = {log_img, c[8*i +: 8]};
  endtask

  // Offer one item; idle beforehand at the sender's rate, then hold until it is taken.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(0, 99) < send_idle) begin
      bytes_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    bytes_ch.valid      <= 1'b1;
    bytes_ch.in_byte    <= b;
    bytes_ch.final_byte <= fin;
    do @(posedge clk); while (!bytes_ch.ready);
    sent++;
  endtask

  // Send the image, marking its last byte as final.
  task automatic send_image();
    foreach (log_img[i]) push_byte(log_img[i], i == log_img.size() - 1);
  endtask

  // Hold the sender until every expected result is in, then let the tail of any
  // header byte work its way through before touching the block again.
  task automatic settle();
    bytes_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_min_seq(input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lrd_pkg::ADDR_MIN_SEQUENCE;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_min = v;
  endtask

  // One random image: mostly well-formed records (some with a bad checksum, which
  // halts the parser for the rest of the image), some cut short, some pure noise.
  task automatic random_image();
    int mode;
    int cut;
    log_img.delete();
    mode = $urandom_range(0, 99);
    if (mode >= 88) begin
      repeat ($urandom_range(1, 40)) log_img = {log_img, 8'($urandom_range(0, 255))};
    end else begin
      repeat ($urandom_range(1, 4)) add_record($urandom_range(0, 7) == 0);
      if (mode >= 72) begin
        cut = $urandom_range(1, log_img.size() - 1);
        while (log_img.size() > cut) void'(log_img.pop_back());
      end
    end
    send_image();
  endtask

  task automatic run_phase(input int s_idle, input int r_idle);
    int start;
    send_idle = s_idle;
    recv_idle = r_idle;
    start     = sent;
    random_image();
    // Pause the sender once after the first image until the block has drained completely.
    settle();
    while (sent - start < PHASE_ITEMS) random_image();
    settle();
  endtask

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= lrd_pkg::ADDR_MIN_SEQUENCE;
    pwdata              <= '0;
    bytes_ch.valid      <= 1'b0;
    bytes_ch.in_byte    <= '0;
    bytes_ch.final_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Top extreme of the minimum first.
    write_min_seq({64{1'b1}});
    send_idle = 21;
    recv_idle = 77;

    // Directed: a lone final kind byte, truncated at once.
    log_img.delete();
    log_img = {log_img, 8'hFF};
    send_image();
    // Directed: all-zero kind and sequence, all-ones id, the largest key length,
    // then the log ends two key bytes in.
    log_img.delete();
    log_img = {log_img, 8'h00};
    repeat (8) log_img = {log_img, 8'hFF};
    repeat (8) log_img = {log_img, 8'h00};
    repeat (4) log_img = {log_img, 8'hFF};
    log_img = {log_img, 8'hFF};
    log_img = {log_img, 8'h00};
    send_image();

    run_phase(21, 77);
    write_min_seq('0);
    run_phase(77, 21);
    write_min_seq({$urandom, $urandom});
    run_phase(0, 0);

    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("log_record_deframer_crc32 verification clean");
    end else begin
      $display("log_record_deframer_crc32 verification failed");
    end
    $finish;
  end

endmodule
